### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the buffer pool RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/rcbp_pkg.sv
// ---------------------------------------------------------------------------
// rcbp_pkg
// Types, codes and pool geometry shared by the buffer pool modules.
// ---------------------------------------------------------------------------
package rcbp_pkg;

   // Pool geometry
   localparam int COMMON_DEPTH  = 32;
   localparam int PURE_DEPTH    = 32;
   localparam int DYNAMIC_DEPTH = 16;
   localparam int POOLS         = 3;
   localparam int TOTAL_DEPTH   = COMMON_DEPTH + PURE_DEPTH + DYNAMIC_DEPTH;
   localparam int ADDR_W        = $clog2(TOTAL_DEPTH);

   // Field widths
   localparam int MODE_W  = 2;
   localparam int POOL_W  = 2;
   localparam int IDX_W   = 5;
   localparam int STAT_W  = 3;
   localparam int LINK_W  = 6;
   localparam int REF_W   = 3;
   localparam int WORD_W  = LINK_W + REF_W;

   localparam logic [REF_W-1:0] REF_MAX = REF_W'(7);

   // Request modes
   localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

   // Pool selects
   localparam logic [POOL_W-1:0] POOL_COMMON  = 2'd0;
   localparam logic [POOL_W-1:0] POOL_PURE    = 2'd1;
   localparam logic [POOL_W-1:0] POOL_DYNAMIC = 2'd2;
   localparam logic [POOL_W-1:0] POOL_BAD     = 2'd3;

   // Result status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd1;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd2;
   localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 3'd3;
   localparam logic [STAT_W-1:0] STAT_BAD_POOL  = 3'd4;
   localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 3'd5;

   // Controller states
   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;   // latch request, issue memory read
      logic commit;   // write back, load result register
   } pool_cmd_type;

   // Number of entries in a pool
   function automatic logic [LINK_W-1:0] pool_depth(input logic [POOL_W-1:0] p);
      logic [LINK_W-1:0] d;
      case (p)
         POOL_COMMON:  d = LINK_W'(COMMON_DEPTH);
         POOL_PURE:    d = LINK_W'(PURE_DEPTH);
         POOL_DYNAMIC: d = LINK_W'(DYNAMIC_DEPTH);
         default:      d = '0;
      endcase
      return d;
   endfunction

   // First address of a pool in the shared entry memory
   function automatic logic [ADDR_W-1:0] pool_base(input logic [POOL_W-1:0] p);
      logic [ADDR_W-1:0] b;
      case (p)
         POOL_PURE:    b = ADDR_W'(COMMON_DEPTH);
         POOL_DYNAMIC: b = ADDR_W'(COMMON_DEPTH + PURE_DEPTH);
         default:      b = '0;
      endcase
      return b;
   endfunction

endpackage

### src/rcbp_ctrl.sv
// ---------------------------------------------------------------------------
// rcbp_ctrl
// Request sequencer: accept, execute, result register handshake.
// ---------------------------------------------------------------------------
module rcbp_ctrl
   import rcbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output pool_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // State and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      out_free   = !rsp_valid_ff || !rsp_stall;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            // wait here until the result register can take the result
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### src/rcbp_datapath.sv
// ---------------------------------------------------------------------------
// rcbp_datapath
// Free list heads, used counters, entry memory (link and reference count)
// and result registers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rcbp_datapath
   import rcbp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  pool_cmd_type        cmd,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [POOL_W-1:0]   req_pool_select,
   input  logic [IDX_W-1:0]    req_entry_index,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [IDX_W-1:0]    rsp_result_index,
   output logic                rsp_entry_freed,
   output logic [LINK_W-1:0]   rsp_used_count
);

   // Control state
   logic [LINK_W-1:0] free_head_ff [POOLS];
   logic [LINK_W-1:0] pool_used_ff [POOLS];
   logic [TOTAL_DEPTH-1:0] valid_ff;

   // Entry memory: {link, refs}
   logic [WORD_W-1:0] mem [TOTAL_DEPTH];

   // Latched request and read data
   logic [MODE_W-1:0] mode_ff;
   logic [POOL_W-1:0] pool_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [WORD_W-1:0] rd_word_ff;
   logic              rd_valid_ff;

   // Result registers
   logic [STAT_W-1:0] status_ff;
   logic [IDX_W-1:0]  result_ff;
   logic              freed_ff;
   logic [LINK_W-1:0] used_ff;

   // Accept-side address
   logic [POOL_W-1:0] req_ps;
   logic [LINK_W-1:0] req_dep;
   logic [LINK_W-1:0] req_off;
   logic              req_in_range;
   logic [ADDR_W-1:0] rd_addr;

   // Execute-side signals
   logic [POOL_W-1:0] ps;
   logic [LINK_W-1:0] dep;
   logic [LINK_W-1:0] head;
   logic [LINK_W-1:0] eff_link;
   logic [REF_W-1:0]  eff_refs;
   logic [REF_W-1:0]  refs_dec;
   logic              pool_ok;
   logic              wr_en;
   logic [WORD_W-1:0] wr_word;
   logic [LINK_W-1:0] head_in;
   logic [LINK_W-1:0] used_in;
   logic [STAT_W-1:0] status_in;
   logic [IDX_W-1:0]  result_in;
   logic              freed_in;
   logic [LINK_W-1:0] used_out_in;

   // Invariant terms
   logic              used_in_bound;
   logic              empty_means_full;

   // Read address: head of the list for allocate, entry for add/release
   always_comb begin
      req_ps  = (req_pool_select == POOL_BAD) ? POOL_COMMON : req_pool_select;
      req_dep = pool_depth(req_pool_select);
      req_off = (req_mode == MODE_ALLOC) ? free_head_ff[req_ps]
                                         : LINK_W'(req_entry_index);
      req_in_range = (req_pool_select != POOL_BAD) && (req_off < req_dep);
      rd_addr = req_in_range ? pool_base(req_ps) + ADDR_W'(req_off) : '0;
   end

   // Request latch and registered memory read
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff     <= req_mode;
         pool_ff     <= req_pool_select;
         idx_ff      <= req_entry_index;
         addr_ff     <= rd_addr;
         rd_word_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // Execute: status, write-back word, head and counter updates
   always_comb begin
      ps       = (pool_ff == POOL_BAD) ? POOL_COMMON : pool_ff;
      pool_ok  = (pool_ff != POOL_BAD);
      dep      = pool_depth(pool_ff);
      head     = free_head_ff[ps];
      // entries never written still hold their reset value
      eff_link = rd_valid_ff ? rd_word_ff[WORD_W-1:REF_W] : head + LINK_W'(1);
      eff_refs = rd_valid_ff ? rd_word_ff[REF_W-1:0] : '0;
      refs_dec = eff_refs - REF_W'(1);

      status_in = STAT_OK;
      result_in = idx_ff;
      freed_in  = 1'b0;
      wr_en     = 1'b0;
      wr_word   = {eff_link, eff_refs};
      head_in   = head;
      used_in   = pool_used_ff[ps];

      if (!pool_ok) begin
         status_in = STAT_BAD_POOL;
         if (mode_ff == MODE_ALLOC) begin
            result_in = '0;
         end
      end else begin
         case (mode_ff)
            MODE_ALLOC: begin
               if (head >= dep) begin
                  status_in = STAT_EMPTY;
                  result_in = '0;
               end else begin
                  wr_en     = 1'b1;
                  wr_word   = {eff_link, REF_W'(1)};
                  head_in   = eff_link;
                  used_in   = pool_used_ff[ps] + LINK_W'(1);
                  result_in = IDX_W'(head);
               end
            end
            MODE_ADD, MODE_RELEASE: begin
               if (LINK_W'(idx_ff) >= dep) begin
                  status_in = STAT_BAD_INDEX;
               end else if (eff_refs == '0) begin
                  status_in = STAT_UNDERFLOW;
               end else if (mode_ff == MODE_ADD) begin
                  if (eff_refs >= REF_MAX) begin
                     status_in = STAT_OVERFLOW;
                  end else begin
                     wr_en   = 1'b1;
                     wr_word = {eff_link, eff_refs + REF_W'(1)};
                  end
               end else begin
                  wr_en = 1'b1;
                  if (refs_dec == '0) begin
                     // last reference gone: push on the free list head
                     wr_word  = {head, refs_dec};
                     head_in  = LINK_W'(idx_ff);
                     freed_in = 1'b1;
                     if (pool_used_ff[ps] != '0) begin
                        used_in = pool_used_ff[ps] - LINK_W'(1);
                     end
                  end else begin
                     wr_word = {eff_link, refs_dec};
                  end
               end
            end
            default: ;
         endcase
      end
      used_out_in = pool_ok ? used_in : '0;
   end

   // Entry memory write
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         mem[addr_ff] <= wr_word;
      end
   end

   // Heads, counters and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < POOLS; p++) begin
            free_head_ff[p] <= '0;
            pool_used_ff[p] <= '0;
         end
         valid_ff <= '0;
      end else if (cmd.commit && pool_ok) begin
         free_head_ff[ps] <= head_in;
         pool_used_ff[ps] <= used_in;
         if (wr_en) begin
            valid_ff[addr_ff] <= 1'b1;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         result_ff <= result_in;
         freed_ff  <= freed_in;
         used_ff   <= used_out_in;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_result_index = result_ff;
   assign rsp_entry_freed  = freed_ff;
   assign rsp_used_count   = used_ff;

   // Used counters within pool size; an empty list means a full pool
   assign used_in_bound = (pool_used_ff[0] <= LINK_W'(COMMON_DEPTH)) &&
                          (pool_used_ff[1] <= LINK_W'(PURE_DEPTH)) &&
                          (pool_used_ff[2] <= LINK_W'(DYNAMIC_DEPTH));
   assign empty_means_full =
      ((free_head_ff[0] != LINK_W'(COMMON_DEPTH)) ||
       (pool_used_ff[0] == LINK_W'(COMMON_DEPTH))) &&
      ((free_head_ff[1] != LINK_W'(PURE_DEPTH)) ||
       (pool_used_ff[1] == LINK_W'(PURE_DEPTH))) &&
      ((free_head_ff[2] != LINK_W'(DYNAMIC_DEPTH)) ||
       (pool_used_ff[2] == LINK_W'(DYNAMIC_DEPTH)));

   // Used counters never exceed the pool size
   `ASSERT_ALWAYS(a_used_bound, clock, reset, used_in_bound, "pool used count above depth")
   // An empty free list means every entry is in use
   `ASSERT_ALWAYS(a_empty_full, clock, reset, empty_means_full, "empty list with unused entries")
   // A freed entry becomes the new head of its list
   `ASSERT_NEXT(a_freed_head, clock, reset, cmd.commit && freed_in, free_head_ff[ps] == LINK_W'(idx_ff), "freed entry not at list head")

endmodule

### src/ref_counted_buffer_pool.sv
// ---------------------------------------------------------------------------
// ref_counted_buffer_pool
// Three fixed buffer pools with LIFO free lists and saturating reference
// counts, built as a sequencer and a datapath.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): mode, pool_select and entry_index; a transfer
//   happens when req_valid is high and req_stall is low. Every request
//   gives exactly one result on the rsp_* channel: status, result_index,
//   entry_freed and used_count, taken when rsp_valid is high and
//   rsp_stall is low.
//   Timing: a request is accepted in the idle state, which reads the entry
//   memory (link and reference count, one shared port) into a register.
//   The execute state then writes the entry back and updates the pool's
//   head and used count as the result is loaded. The next request is taken
//   in the cycle after the result is loaded, so the block takes no new
//   request before the result of the last one is in the result register.
//   Stall: a result held by rsp_stall does not block the next request from
//   being accepted; its execute cycle waits until the result register is
//   free, and req_stall stays high meanwhile.
//   Reset: synchronous; all entries become free in index order, reference
//   counts clear at once through per-entry valid bits, used counters reset
//   to zero, and the block accepts a request in the first cycle after reset.
// ---------------------------------------------------------------------------
module ref_counted_buffer_pool
   import rcbp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [POOL_W-1:0]   req_pool_select,
   input  logic [IDX_W-1:0]    req_entry_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [IDX_W-1:0]    rsp_result_index,
   output logic                rsp_entry_freed,
   output logic [LINK_W-1:0]   rsp_used_count
);

   pool_cmd_type cmd;

   // Sequencer
   rcbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Pool state and result datapath
   rcbp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_mode         (req_mode),
      .req_pool_select  (req_pool_select),
      .req_entry_index  (req_entry_index),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index),
      .rsp_entry_freed  (rsp_entry_freed),
      .rsp_used_count   (rsp_used_count)
   );

endmodule

### tb/sv/tb_ref_counted_buffer_pool.sv
// ---------------------------------------------------------------------------
// tb_ref_counted_buffer_pool
// Self-checking bench for the three-pool reference-counted buffer allocator.
// A shadow of the pools (free lists, counts, used counters) predicts every
// result. A second shadow runs ahead at generation time so that random
// traffic can aim add and release requests at live entries. Sender idling
// and receiver stalls vary over three phases.
// ---------------------------------------------------------------------------
module tb_ref_counted_buffer_pool;
   import rcbp_pkg::*;

   localparam int MAX_DEPTH  = 32;
   localparam int CYCLE_CAP  = 200000;
   localparam int PHASE_REQS = 550;
   localparam int PRINT_CAP  = 200;

   // Mode code with no operation behind it
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   // Shadow copies: copy 0 checks accepted requests, copy 1 steers generation
   localparam int CHK = 0;
   localparam int GEN = 1;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [POOL_W-1:0] pool;
      logic [IDX_W-1:0]  idx;
   } pool_req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [IDX_W-1:0]  index;
      logic              freed;
      logic [LINK_W-1:0] used;
   } pool_rsp_type;

   logic clock;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [MODE_W-1:0] req_mode = '0;
   logic [POOL_W-1:0] req_pool_select = '0;
   logic [IDX_W-1:0]  req_entry_index = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [IDX_W-1:0]  rsp_result_index;
   logic              rsp_entry_freed;
   logic [LINK_W-1:0] rsp_used_count;

   // Pool shadow state
   logic [LINK_W-1:0] head_of   [2][POOLS];
   logic [LINK_W-1:0] in_use    [2][POOLS];
   logic [LINK_W-1:0] next_free [2][POOLS][MAX_DEPTH];
   logic [REF_W-1:0]  ref_cnt   [2][POOLS][MAX_DEPTH];

   pool_req_type queued_requests[$];
   pool_rsp_type pending_results[$];
   pool_req_type next_req;
   pool_req_type taken_req;
   pool_rsp_type want;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fail_count     = 0;
   int cycle_count    = 0;

   ref_counted_buffer_pool dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_pool_select  (req_pool_select),
      .req_entry_index  (req_entry_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index),
      .rsp_entry_freed  (rsp_entry_freed),
      .rsp_used_count   (rsp_used_count)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int depth_of(input logic [POOL_W-1:0] p);
      case (p)
         POOL_COMMON: return COMMON_DEPTH;
         POOL_PURE:   return PURE_DEPTH;
         default:     return DYNAMIC_DEPTH;
      endcase
   endfunction

   // All entries free, lists in index order
   task automatic clear_pools(input int c);
      for (int p = 0; p < POOLS; p++) begin
         head_of[c][p] = '0;
         in_use[c][p]  = '0;
         for (int i = 0; i < MAX_DEPTH; i++) begin
            next_free[c][p][i] = LINK_W'(i + 1);
            ref_cnt[c][p][i]   = '0;
         end
      end
   endtask

   // Applies one request to a shadow copy and returns the result it gives
   function automatic pool_rsp_type pool_transact(input int c, input pool_req_type r);
      pool_rsp_type o;
      int d;
      int h;
      o.status = STAT_OK;
      o.index  = r.idx;
      o.freed  = 1'b0;
      o.used   = '0;
      if (r.pool == POOL_BAD) begin
         o.status = STAT_BAD_POOL;
         if (r.mode == MODE_ALLOC)
            o.index = '0;
      end else begin
         d = depth_of(r.pool);
         if (r.mode == MODE_ALLOC) begin
            h = head_of[c][r.pool];
            if (h >= d) begin
               o.status = STAT_EMPTY;
               o.index  = '0;
            end else begin
               head_of[c][r.pool]    = next_free[c][r.pool][h];
               ref_cnt[c][r.pool][h] = REF_W'(1);
               in_use[c][r.pool]     = in_use[c][r.pool] + LINK_W'(1);
               o.index = IDX_W'(h);
            end
         end else if (r.mode == MODE_ADD || r.mode == MODE_RELEASE) begin
            if (r.idx >= d)
               o.status = STAT_BAD_INDEX;
            else if (ref_cnt[c][r.pool][r.idx] == '0)
               o.status = STAT_UNDERFLOW;
            else if (r.mode == MODE_ADD) begin
               if (ref_cnt[c][r.pool][r.idx] >= REF_MAX)
                  o.status = STAT_OVERFLOW;
               else
                  ref_cnt[c][r.pool][r.idx] = ref_cnt[c][r.pool][r.idx] + REF_W'(1);
            end else begin
               ref_cnt[c][r.pool][r.idx] = ref_cnt[c][r.pool][r.idx] - REF_W'(1);
               // last reference gone: entry goes back on the list head
               if (ref_cnt[c][r.pool][r.idx] == '0) begin
                  next_free[c][r.pool][r.idx] = head_of[c][r.pool];
                  head_of[c][r.pool] = LINK_W'(r.idx);
                  if (in_use[c][r.pool] != '0)
                     in_use[c][r.pool] = in_use[c][r.pool] - LINK_W'(1);
                  o.freed = 1'b1;
               end
            end
         end
         o.used = in_use[c][r.pool];
      end
      return o;
   endfunction

   // Queue a request and advance the generation shadow
   task automatic queue_request(input logic [MODE_W-1:0] m, input logic [POOL_W-1:0] p,
                                input logic [IDX_W-1:0] i);
      pool_req_type r;
      pool_rsp_type unused_rsp;
      r.mode = m;
      r.pool = p;
      r.idx  = i;
      queued_requests.push_back(r);
      unused_rsp = pool_transact(GEN, r);
   endtask

   // Find an entry holding references, starting at a random point
   function automatic logic find_live(input logic [POOL_W-1:0] p, output logic [IDX_W-1:0] e);
      int d;
      int start;
      int k;
      d = depth_of(p);
      start = $urandom_range(0, d - 1);
      e = '0;
      for (int n = 0; n < d; n++) begin
         k = (start + n) % d;
         if (ref_cnt[GEN][p][k] != '0) begin
            e = IDX_W'(k);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Reset state, field extremes and the bad pool, bad index, overflow and underflow cases
   task automatic directed_requests();
      queue_request(MODE_ALLOC, POOL_COMMON, 5'd31);
      queue_request(MODE_ALLOC, POOL_PURE, 5'd0);
      queue_request(MODE_ALLOC, POOL_DYNAMIC, 5'd17);
      queue_request(MODE_ALLOC, POOL_BAD, 5'd31);
      queue_request(MODE_ADD, POOL_BAD, 5'd5);
      queue_request(MODE_SPARE, POOL_BAD, 5'd31);
      queue_request(MODE_SPARE, POOL_COMMON, 5'd17);
      // count up to the saturation point, then one more
      repeat (6) queue_request(MODE_ADD, POOL_COMMON, 5'd0);
      queue_request(MODE_ADD, POOL_COMMON, 5'd0);
      queue_request(MODE_ADD, POOL_COMMON, 5'd31);
      queue_request(MODE_RELEASE, POOL_PURE, 5'd1);
      queue_request(MODE_ADD, POOL_DYNAMIC, 5'd16);
      queue_request(MODE_RELEASE, POOL_DYNAMIC, 5'd31);
      queue_request(MODE_RELEASE, POOL_PURE, 5'd0);
      queue_request(MODE_RELEASE, POOL_DYNAMIC, 5'd0);
      queue_request(MODE_RELEASE, POOL_DYNAMIC, 5'd0);
      queue_request(MODE_ALLOC, POOL_DYNAMIC, 5'd0);
   endtask

   // Mostly well-formed traffic against live entries, in fill and drain bursts
   task automatic random_requests(input int n_reqs);
      int sent;
      int burst_left;
      int alloc_pct;
      int roll;
      int reps;
      logic [POOL_W-1:0] hot_pool;
      logic [POOL_W-1:0] p;
      logic [IDX_W-1:0] e;
      sent = 0;
      burst_left = 0;
      alloc_pct = 40;
      hot_pool = POOL_COMMON;
      while (sent < n_reqs) begin
         if (burst_left == 0) begin
            case ($urandom_range(0, 2))
               0:       alloc_pct = 85;
               1:       alloc_pct = 15;
               default: alloc_pct = 45;
            endcase
            hot_pool = POOL_W'($urandom_range(0, 2));
            burst_left = $urandom_range(40, 120);
         end
         burst_left--;
         p = ($urandom_range(0, 99) < 60) ? hot_pool : POOL_W'($urandom_range(0, 2));
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            // noise over the whole field ranges
            queue_request(MODE_W'($urandom_range(0, 3)), POOL_W'($urandom_range(0, 3)),
                          IDX_W'($urandom_range(0, 31)));
            sent++;
         end else if (roll < 12 && find_live(p, e)) begin
            // drive one entry into saturation and back down
            reps = $urandom_range(6, 8);
            repeat (reps) queue_request(MODE_ADD, p, e);
            sent += reps;
            reps = $urandom_range(5, 9);
            repeat (reps) queue_request(MODE_RELEASE, p, e);
            sent += reps;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < alloc_pct || !find_live(p, e))
               queue_request(MODE_ALLOC, p, IDX_W'($urandom_range(0, 31)));
            else if (roll < alloc_pct + (100 - alloc_pct) / 4)
               queue_request(MODE_ADD, p, e);
            else
               queue_request(MODE_RELEASE, p, e);
            sent++;
         end
      end
   endtask

   task automatic flag_mismatch(input string what);
      fail_count++;
      if (fail_count <= PRINT_CAP)
         $display("cycle %0d: %s", cycle_count, what);
   endtask

   // Request driver: prediction happens at the accepting edge
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            taken_req = {req_mode, req_pool_select, req_entry_index};
            pending_results.push_back(pool_transact(CHK, taken_req));
         end
         if (!req_valid || !req_stall) begin
            if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_req = queued_requests.pop_front();
               req_valid       <= 1'b1;
               req_mode        <= next_req.mode;
               req_pool_select <= next_req.pool;
               req_entry_index <= next_req.idx;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Result monitor: each transfer against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("result with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               flag_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_result_index !== want.index)
               flag_mismatch($sformatf("result_index %0d, want %0d",
                                       rsp_result_index, want.index));
            if (rsp_entry_freed !== want.freed)
               flag_mismatch($sformatf("entry_freed %0b, want %0b",
                                       rsp_entry_freed, want.freed));
            if (rsp_used_count !== want.used)
               flag_mismatch($sformatf("used_count %0d, want %0d",
                                       rsp_used_count, want.used));
         end
      end
   end

   // Watchdog
   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_CAP; cycle_count++)
         @(posedge clock);
      $display("ref_counted_buffer_pool regression: fail");
      $finish;
   end

   // Sequence: reset, then three idling phases, draining between them
   initial begin
      clear_pools(CHK);
      clear_pools(GEN);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         @(negedge clock);
         case (phase)
            0: begin
               send_idle_pct  = 31;
               recv_stall_pct = 49;
               directed_requests();
            end
            1: begin
               send_idle_pct  = 49;
               recv_stall_pct = 31;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         random_requests(PHASE_REQS);
         // wait until every queued request is sent and every result is back
         while (queued_requests.size() != 0 || req_valid || pending_results.size() != 0)
            @(negedge clock);
      end
      repeat (8) @(negedge clock);
      if (fail_count == 0)
         $display("ref_counted_buffer_pool regression: pass");
      else
         $display("ref_counted_buffer_pool regression: fail");
      $finish;
   end

endmodule
